// File: hw/rtl/hnft_pkg.sv
// Shared types and constants of the HDLC NRZI frame transmitter.
package hnft_pkg;

   localparam int MIN_FRAME_BYTES = 18;
   localparam int FBC_W           = 5;
   localparam int PRE_W           = 5;
   localparam int LEAD_W          = 6;
   localparam int TAIL_W          = 2;
   localparam int CSR_W           = LEAD_W;
   localparam int MAX_PREAMBLE    = 16;
   localparam int MAX_LEAD        = 32;

   localparam logic [7:0] PREAMBLE_BYTE = 8'hAA;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   // Bit accumulator: up to seven partial bits plus a ten-bit chunk
   localparam int CHUNK_W = 10;
   localparam int ACC_W   = 17;
   localparam int CNT_W   = 5;
   localparam int N_W     = 4;
   localparam int POS_W   = 4;
   localparam int RUN_W   = 3;

   typedef enum logic [1:0] {
      CSR_PREAMBLE = 2'd0,
      CSR_LEAD     = 2'd1,
      CSR_TAIL     = 2'd2,
      CSR_LEVEL    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [7:0]        data;
      logic              first;
      logic              last;
      logic [PRE_W-1:0]  pre_n;
      logic [LEAD_W-1:0] lead_n;
      logic [TAIL_W-1:0] tail_n;
      logic              init_level;
      logic              too_short;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_out_type;

endpackage

// File: hw/rtl/hdlc_nrzi_frame_transmitter_unit.sv
// Top level of the HDLC NRZI frame transmitter.
// Frame bytes (FCS included) enter on the req_ channel and leave as NRZI air
// bytes on the rsp_ channel, first transmitted bit in bit 7. A first byte
// starts a frame with the preamble bytes and lead flags set in the csr_
// registers; a last byte adds the closing and tail flags, fills the byte at
// the held level and pads to an even byte count with one more flag. The front
// end takes one transaction per cycle, unless the queue is full, into a
// four-entry command queue. The bit engine takes a command off the queue
// while idle, then codes it one chunk at a time: a data byte (up to ten
// bits with stuffing), a preamble byte, a flag or the fill step. A first
// byte codes its preamble bytes and lead flags first, a last byte adds the
// closing and tail flags, fill and padding flag. The engine pauses while a
// whole coded byte waits; output drains one air byte per unstalled cycle.
module hdlc_nrzi_frame_transmitter_unit import hnft_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_data_byte,
   input  logic             req_first_byte,
   input  logic             req_last_byte,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_air_byte,
   output logic             rsp_end_of_frame,
   output logic             rsp_too_short,
   input  logic             csr_write_enable,
   input  logic [1:0]       csr_index,
   input  logic [CSR_W-1:0] csr_data
);

   logic          q_full, push, pop;
   cmd_type       push_cmd;
   queue_out_type q_out;

   hnft_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_first_byte   (req_first_byte),
      .req_last_byte    (req_last_byte),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .q_full           (q_full),
      .push             (push),
      .push_cmd         (push_cmd)
   );

   hnft_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (pop),
      .q_out    (q_out)
   );

   hnft_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_out            (q_out),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_air_byte     (rsp_air_byte),
      .rsp_end_of_frame (rsp_end_of_frame),
      .rsp_too_short    (rsp_too_short)
   );

endmodule

// File: hw/rtl/hnft_front.sv
// Front end: configuration registers, frame byte count and command building.
module hnft_front import hnft_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_data_byte,
   input  logic              req_first_byte,
   input  logic              req_last_byte,
   input  logic              csr_write_enable,
   input  logic [1:0]        csr_index,
   input  logic [CSR_W-1:0]  csr_data,
   input  logic              q_full,
   output logic              push,
   output cmd_type           push_cmd
);

   logic [PRE_W-1:0]  preamble_ff, preamble_in;
   logic [LEAD_W-1:0] lead_ff, lead_in;
   logic [TAIL_W-1:0] tail_ff, tail_in;
   logic              level_ff, level_in;
   logic [FBC_W-1:0]  fbc_ff, fbc_in;
   logic [FBC_W-1:0]  fbc_base, fbc_inc;

   always_comb begin
      preamble_in = preamble_ff;
      lead_in     = lead_ff;
      tail_in     = tail_ff;
      level_in    = level_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_PREAMBLE: preamble_in = csr_data[PRE_W-1:0];
            CSR_LEAD:     lead_in     = csr_data[LEAD_W-1:0];
            CSR_TAIL:     tail_in     = csr_data[TAIL_W-1:0];
            CSR_LEVEL:    level_in    = csr_data[0];
            default:      ;
         endcase
      end
   end

   assign req_stall = q_full;
   assign push      = req_valid && !q_full;

   // Frame byte count restarts on a first byte, saturates at the minimum
   always_comb begin
      fbc_base = req_first_byte ? '0 : fbc_ff;
      fbc_inc  = (fbc_base < FBC_W'(MIN_FRAME_BYTES)) ? fbc_base + FBC_W'(1) : fbc_base;
      fbc_in   = fbc_ff;
      if (push) begin
         fbc_in = req_last_byte ? '0 : fbc_inc;
      end
   end

   always_comb begin
      push_cmd.data       = req_data_byte;
      push_cmd.first      = req_first_byte;
      push_cmd.last       = req_last_byte;
      push_cmd.pre_n      = (preamble_ff > PRE_W'(MAX_PREAMBLE)) ? PRE_W'(MAX_PREAMBLE)
                                                                 : preamble_ff;
      if (lead_ff == '0) begin
         push_cmd.lead_n = LEAD_W'(1);
      end else if (lead_ff > LEAD_W'(MAX_LEAD)) begin
         push_cmd.lead_n = LEAD_W'(MAX_LEAD);
      end else begin
         push_cmd.lead_n = lead_ff;
      end
      push_cmd.tail_n     = tail_ff;
      push_cmd.init_level = level_ff;
      push_cmd.too_short  = fbc_inc < FBC_W'(MIN_FRAME_BYTES);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         preamble_ff <= '0;
         lead_ff     <= LEAD_W'(1);
         tail_ff     <= TAIL_W'(1);
         level_ff    <= 1'b0;
         fbc_ff      <= '0;
      end else begin
         preamble_ff <= preamble_in;
         lead_ff     <= lead_in;
         tail_ff     <= tail_in;
         level_ff    <= level_in;
         fbc_ff      <= fbc_in;
      end
   end

endmodule

// File: hw/rtl/hnft_queue.sv
// Short command queue between the front end and the bit engine.
module hnft_queue import hnft_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  cmd_type       push_cmd,
   output logic          full,
   input  logic          pop,
   output queue_out_type q_out
);

   cmd_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] head_ff, head_in;
   logic [QPTR_W-1:0] tail_ff, tail_in;
   logic [QPTR_W:0]   count_ff, count_in;

   assign full        = count_ff == (QPTR_W+1)'(QUEUE_DEPTH);
   assign q_out.valid = count_ff != '0;
   assign q_out.cmd   = slot_ff[head_ff];

   always_comb begin
      head_in  = pop  ? head_ff + QPTR_W'(1) : head_ff;
      tail_in  = push ? tail_ff + QPTR_W'(1) : tail_ff;
      count_in = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[tail_ff] <= push_cmd;
      end
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

endmodule

// File: hw/rtl/hnft_back.sv
// Back end: preamble, flag, stuffing and NRZI engine with byte packing.
module hnft_back import hnft_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  queue_out_type q_out,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [7:0]    rsp_air_byte,
   output logic          rsp_end_of_frame,
   output logic          rsp_too_short
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRE,
      ST_LEAD,
      ST_DATA,
      ST_CLOSE,
      ST_FILL,
      ST_PARITY
   } state_type;

   state_type         state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [PRE_W-1:0]  pre_left_ff, pre_left_in;
   logic [LEAD_W-1:0] lead_left_ff, lead_left_in;
   logic [TAIL_W-1:0] tail_left_ff, tail_left_in;
   logic              start_ff, start_in;
   logic              level_ff, level_in;
   logic [RUN_W-1:0]  run_ff, run_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              eof_ff, eof_in;
   logic              short_ff, short_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        air_ff, air_in;
   logic              eof_out_ff, eof_out_in;
   logic              short_out_ff, short_out_in;

   logic              slot_free, drain, step;
   logic [CNT_W-1:0]  rem, rem_e, top_idx;
   logic              lvl_e, lvl_new;
   logic [RUN_W-1:0]  run_e, run_new;
   logic [POS_W-1:0]  pos_e, pos_new;
   logic [CHUNK_W-1:0] chunk;
   logic [N_W-1:0]    n;
   logic              phase_final;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign drain     = slot_free && (cnt_ff >= CNT_W'(8));
   assign rem       = drain ? cnt_ff - CNT_W'(8) : cnt_ff;
   assign top_idx   = cnt_ff - CNT_W'(1);
   // Code the next chunk only when no whole byte is left waiting
   assign step      = (state_ff != ST_IDLE) && (rem < CNT_W'(8));

   // A frame start drops partial bits and restarts level, run and position
   assign lvl_e = start_ff ? cmd_ff.init_level : level_ff;
   assign run_e = start_ff ? '0 : run_ff;
   assign pos_e = start_ff ? '0 : pos_ff;
   assign rem_e = start_ff ? '0 : rem;

   // Chunk of air bits for the current phase, first bit highest
   always_comb begin
      chunk   = '0;
      n       = '0;
      lvl_new = lvl_e;
      run_new = run_e;
      case (state_ff)
         ST_PRE: begin
            chunk = CHUNK_W'(PREAMBLE_BYTE);
            n     = N_W'(8);
         end
         ST_LEAD, ST_CLOSE, ST_PARITY: begin
            // Flag: toggle, hold six times, toggle back
            chunk   = lvl_e ? CHUNK_W'(8'b0000_0001) : CHUNK_W'(8'b1111_1110);
            n       = N_W'(8);
            run_new = '0;
         end
         ST_DATA: begin
            for (int i = 0; i < 8; i++) begin
               if (!cmd_ff.data[i]) begin
                  lvl_new = ~lvl_new;
               end
               chunk = {chunk[CHUNK_W-2:0], lvl_new};
               n     = n + N_W'(1);
               if (cmd_ff.data[i]) begin
                  if (run_new == RUN_W'(4)) begin
                     // insert a zero after five ones
                     lvl_new = ~lvl_new;
                     chunk   = {chunk[CHUNK_W-2:0], lvl_new};
                     n       = n + N_W'(1);
                     run_new = '0;
                  end else begin
                     run_new = run_new + RUN_W'(1);
                  end
               end else begin
                  run_new = '0;
               end
            end
         end
         ST_FILL: begin
            n     = N_W'(8) - N_W'(pos_e[2:0]);
            chunk = lvl_e ? ~({CHUNK_W{1'b1}} << n) : '0;
         end
         default: ;
      endcase
      pos_new = pos_e + POS_W'(n);
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      pre_left_in  = pre_left_ff;
      lead_left_in = lead_left_ff;
      tail_left_in = tail_left_ff;
      start_in     = start_ff;
      level_in     = level_ff;
      run_in       = run_ff;
      pos_in       = pos_ff;
      acc_in       = acc_ff;
      cnt_in       = rem;
      eof_in       = eof_ff;
      short_in     = short_ff;
      pop          = 1'b0;
      phase_final  = 1'b0;

      rsp_valid_in = rsp_valid_ff;
      air_in       = air_ff;
      eof_out_in   = eof_out_ff;
      short_out_in = short_out_ff;
      if (slot_free) begin
         rsp_valid_in = drain;
      end
      if (drain) begin
         air_in       = acc_ff[top_idx -: 8];
         eof_out_in   = eof_ff && (cnt_ff == CNT_W'(8));
         short_out_in = eof_ff && (cnt_ff == CNT_W'(8)) && short_ff;
         if (cnt_ff == CNT_W'(8)) begin
            eof_in = 1'b0;
         end
      end

      if ((state_ff == ST_IDLE) && q_out.valid) begin
         pop          = 1'b1;
         cmd_in       = q_out.cmd;
         start_in     = q_out.cmd.first;
         pre_left_in  = q_out.cmd.pre_n;
         lead_left_in = q_out.cmd.lead_n;
         tail_left_in = q_out.cmd.tail_n;
         if (!q_out.cmd.first) begin
            state_in = ST_DATA;
         end else if (q_out.cmd.pre_n != '0) begin
            state_in = ST_PRE;
         end else begin
            state_in = ST_LEAD;
         end
      end

      if (step) begin
         start_in = 1'b0;
         level_in = lvl_new;
         run_in   = run_new;
         pos_in   = pos_new;
         acc_in   = (acc_ff << n) | ACC_W'(chunk);
         cnt_in   = rem_e + CNT_W'(n);
         case (state_ff)
            ST_PRE: begin
               pre_left_in = pre_left_ff - PRE_W'(1);
               if (pre_left_ff == PRE_W'(1)) begin
                  state_in = ST_LEAD;
               end
            end
            ST_LEAD: begin
               lead_left_in = lead_left_ff - LEAD_W'(1);
               if (lead_left_ff == LEAD_W'(1)) begin
                  state_in = ST_DATA;
               end
            end
            ST_DATA: begin
               state_in = cmd_ff.last ? ST_CLOSE : ST_IDLE;
            end
            ST_CLOSE: begin
               if (tail_left_ff != '0) begin
                  tail_left_in = tail_left_ff - TAIL_W'(1);
               end else if (pos_new[2:0] != '0) begin
                  state_in = ST_FILL;
               end else if (pos_new[3]) begin
                  state_in = ST_PARITY;
               end else begin
                  phase_final = 1'b1;
               end
            end
            ST_FILL: begin
               if (pos_new[3]) begin
                  state_in = ST_PARITY;
               end else begin
                  phase_final = 1'b1;
               end
            end
            ST_PARITY: begin
               phase_final = 1'b1;
            end
            default: ;
         endcase
         if (phase_final) begin
            // the last byte now in the accumulator closes the frame
            state_in = ST_IDLE;
            eof_in   = 1'b1;
            short_in = cmd_ff.too_short;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      pre_left_ff  <= pre_left_in;
      lead_left_ff <= lead_left_in;
      tail_left_ff <= tail_left_in;
      acc_ff       <= acc_in;
      short_ff     <= short_in;
      air_ff       <= air_in;
      eof_out_ff   <= eof_out_in;
      short_out_ff <= short_out_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         level_ff     <= 1'b0;
         run_ff       <= '0;
         pos_ff       <= '0;
         cnt_ff       <= '0;
         eof_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         level_ff     <= level_in;
         run_ff       <= run_in;
         pos_ff       <= pos_in;
         cnt_ff       <= cnt_in;
         eof_ff       <= eof_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_air_byte     = air_ff;
   assign rsp_end_of_frame = eof_out_ff;
   assign rsp_too_short    = short_out_ff;

   acc_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(ACC_W))
      else $error("bit accumulator count out of range");

   eof_aligned: assert property (@(posedge clock) disable iff (reset)
      eof_ff |-> (cnt_ff == CNT_W'(8)) || (cnt_ff == CNT_W'(16)))
      else $error("frame end mark without whole bytes behind it");

   eof_not_overrun: assert property (@(posedge clock) disable iff (reset)
      (eof_ff && step) |-> (drain && (cnt_ff == CNT_W'(8))))
      else $error("new bits coded before frame end byte left");

   short_with_eof: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && short_out_ff) |-> eof_out_ff)
      else $error("short mark on a byte that does not end a frame");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the HDLC NRZI frame transmitter: frames vs a bit-level predictor.
module tb;
   import hnft_pkg::*;

   localparam logic [7:0] HDLC_FLAG     = 8'h7E;
   localparam int         CYCLE_LIMIT   = 2000000;
   localparam int         RANDOM_ITEMS  = 410;
   localparam int         SETTLE_CYCLES = 30;
   localparam int         MAX_PRINTED   = 100;

   typedef struct packed {
      logic [7:0] air_byte;
      logic       end_of_frame;
      logic       too_short;
   } air_result_t;

   // Predicts the air byte stream and checks the block's output against it.
   class air_byte_scoreboard;
      logic [PRE_W-1:0]  preamble_n  = '0;
      logic [LEAD_W-1:0] lead_n      = LEAD_W'(1);
      logic [TAIL_W-1:0] tail_n      = TAIL_W'(1);
      logic              start_level = 1'b0;
      logic              level       = 1'b0;
      logic [RUN_W-1:0]  ones_run    = '0;
      logic [6:0]        held_bits   = '0;
      logic [2:0]        held_count  = '0;
      logic              odd_bytes   = 1'b0;
      logic [FBC_W-1:0]  frame_bytes = '0;
      air_result_t       expected_air[$];
      int                errors      = 0;

      function void set_register(csr_index_type index, logic [CSR_W-1:0] value);
         case (index)
            CSR_PREAMBLE: preamble_n = value[PRE_W-1:0];
            CSR_LEAD: lead_n = value[LEAD_W-1:0];
            CSR_TAIL: tail_n = value[TAIL_W-1:0];
            CSR_LEVEL: start_level = value[0];
            default: ;
         endcase
      endfunction

      function void push_bit(logic b);
         air_result_t item;
         if (held_count == 3'd7) begin
            item.air_byte = {held_bits, b};
            item.end_of_frame = 1'b0;
            item.too_short = 1'b0;
            expected_air.push_back(item);
            odd_bytes = ~odd_bytes;
            held_bits = '0;
            held_count = '0;
         end else begin
            held_bits = {held_bits[5:0], b};
            held_count = held_count + 3'd1;
         end
      endfunction

      // a zero toggles the line, a one holds it
      function void push_coded(logic b);
         if (!b)
            level = ~level;
         push_bit(level);
      endfunction

      function void push_flag();
         ones_run = '0;
         for (int i = 0; i < 8; i++)
            push_coded(HDLC_FLAG[i]);
      endfunction

      function void push_data(logic [7:0] data);
         for (int i = 0; i < 8; i++) begin
            push_coded(data[i]);
            if (!data[i]) begin
               ones_run = '0;
            end else begin
               ones_run = ones_run + 1'b1;
               if (ones_run == 5) begin
                  push_coded(1'b0);
                  ones_run = '0;
               end
            end
         end
      endfunction

      function void note_frame_byte(logic [7:0] data, logic is_first, logic is_last);
         int pre_count;
         int flag_count;
         int last_pos;
         if (is_first) begin
            pre_count = (preamble_n > MAX_PREAMBLE) ? MAX_PREAMBLE : int'(preamble_n);
            if (lead_n == 0)
               flag_count = 1;
            else
               flag_count = (lead_n > MAX_LEAD) ? MAX_LEAD : int'(lead_n);
            // drop unfinished bits and start afresh
            held_bits = '0;
            held_count = '0;
            odd_bytes = 1'b0;
            frame_bytes = '0;
            ones_run = '0;
            level = start_level;
            for (int i = 0; i < pre_count; i++)
               for (int b = 7; b >= 0; b--)
                  push_bit(PREAMBLE_BYTE[b]);
            for (int i = 0; i < flag_count; i++)
               push_flag();
         end
         push_data(data);
         if (frame_bytes < MIN_FRAME_BYTES)
            frame_bytes = frame_bytes + 1'b1;
         if (is_last) begin
            push_flag();
            for (int i = 0; i < int'(tail_n); i++)
               push_flag();
            while (held_count != 0)
               push_coded(1'b1);
            if (odd_bytes)
               push_flag();
            last_pos = expected_air.size() - 1;
            expected_air[last_pos].end_of_frame = 1'b1;
            expected_air[last_pos].too_short = (frame_bytes < MIN_FRAME_BYTES);
            frame_bytes = '0;
            odd_bytes = 1'b0;
         end
      endfunction

      task report(string msg);
         if (errors < MAX_PRINTED)
            $display("%0t: %s", $time, msg);
         errors++;
      endtask

      task check_air_byte(logic [7:0] air, logic eof, logic short_flag);
         air_result_t want;
         if (expected_air.size() == 0) begin
            report($sformatf("air byte %02h with nothing expected", air));
         end else begin
            want = expected_air.pop_front();
            if (air !== want.air_byte)
               report($sformatf("air_byte %02h, expected %02h", air, want.air_byte));
            if (eof !== want.end_of_frame)
               report($sformatf("end_of_frame %b, expected %b", eof, want.end_of_frame));
            if (short_flag !== want.too_short)
               report($sformatf("too_short %b, expected %b", short_flag, want.too_short));
         end
      endtask
   endclass

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   logic [7:0]       req_data_byte;
   logic             req_first_byte;
   logic             req_last_byte;
   logic             rsp_valid;
   logic             rsp_stall;
   logic [7:0]       rsp_air_byte;
   logic             rsp_end_of_frame;
   logic             rsp_too_short;
   logic             csr_write_enable;
   logic [1:0]       csr_index;
   logic [CSR_W-1:0] csr_data;

   air_byte_scoreboard sb;
   bit                 quiet_phase;
   int                 items_sent;
   int                 cycle_count;

   hdlc_nrzi_frame_transmitter_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_first_byte   (req_first_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_air_byte     (rsp_air_byte),
      .rsp_end_of_frame (rsp_end_of_frame),
      .rsp_too_short    (rsp_too_short),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 12);
      else
         return $urandom_range(20, 60);
   endfunction

   always @(posedge clock) begin
      if (reset === 1'b0) begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
            sb.check_air_byte(rsp_air_byte, rsp_end_of_frame, rsp_too_short);
         if (req_valid === 1'b1 && req_stall === 1'b0)
            sb.note_frame_byte(req_data_byte, req_first_byte, req_last_byte);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   // receiver back-pressure
   initial begin
      int run;
      int hold;
      rsp_stall = 1'b0;
      @(posedge clock);
      forever begin
         run = $urandom_range(1, 12);
         rsp_stall <= 1'b0;
         repeat (run) @(posedge clock);
         hold = quiet_phase ? 0 : pick_gap();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
      end
   end

   task automatic send_frame_byte(input logic [7:0] data, input logic is_first,
                                  input logic is_last);
      int gap;
      gap = quiet_phase ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= data;
      req_first_byte <= is_first;
      req_last_byte <= is_last;
      // hold the transaction until it is taken
      do @(posedge clock); while (req_stall !== 1'b0);
      items_sent++;
   endtask

   task automatic send_frame(input int len, input bit noisy);
      logic [7:0] data;
      int         r;
      for (int i = 0; i < len; i++) begin
         r = $urandom_range(0, 9);
         case (r)
            0: data = 8'hFF;
            1: data = 8'h00;
            2: data = HDLC_FLAG;
            3: data = $urandom_range(0, 1) ? 8'h1F : 8'hF8;
            default: data = 8'($urandom_range(0, 255));
         endcase
         if (noisy)
            send_frame_byte(data, $urandom_range(0, 4) == 0, $urandom_range(0, 4) == 0);
         else
            send_frame_byte(data, i == 0, i == len - 1);
      end
   endtask

   task automatic release_request();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      while (sb.expected_air.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_registers(input int pre, input int lead, input int tail,
                                    input int start);
      int            value[4];
      csr_index_type order[4];
      value = '{pre, lead, tail, start};
      order = '{CSR_PREAMBLE, CSR_LEAD, CSR_TAIL, CSR_LEVEL};
      csr_write_enable <= 1'b1;
      for (int i = 0; i < 4; i++) begin
         csr_index <= order[i];
         csr_data <= CSR_W'(value[i]);
         sb.set_register(order[i], CSR_W'(value[i]));
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      int frames;
      int pre;
      int lead;
      int len_pick;
      int len;
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = 8'h00;
      req_first_byte = 1'b0;
      req_last_byte = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = CSR_PREAMBLE;
      csr_data = '0;
      quiet_phase = 1'b0;
      items_sent = 0;
      cycle_count = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: bytes with no first mark continue from reset state
      send_frame_byte(8'h00, 1'b0, 1'b0);
      send_frame_byte(8'hFF, 1'b0, 1'b0);
      send_frame_byte(HDLC_FLAG, 1'b0, 1'b1);
      send_frame_byte(8'hFF, 1'b1, 1'b1);
      send_frame_byte(8'h01, 1'b0, 1'b0);
      send_frame_byte(8'h80, 1'b0, 1'b1);
      send_frame_byte(8'h00, 1'b1, 1'b0);
      send_frame_byte(8'h1F, 1'b0, 1'b0);
      send_frame_byte(8'hF8, 1'b0, 1'b1);
      // restart while a frame is open
      send_frame_byte(8'h3E, 1'b1, 1'b0);
      send_frame_byte(8'hAA, 1'b1, 1'b0);
      send_frame_byte(8'h55, 1'b0, 1'b1);
      release_request();
      wait_idle();

      // oversized preamble and lead counts clamp
      program_registers(31, 63, 3, 1);
      send_frame_byte(8'hFF, 1'b1, 1'b0);
      send_frame_byte(8'hFF, 1'b0, 1'b1);
      send_frame_byte(8'h5A, 1'b1, 1'b1);
      release_request();
      wait_idle();

      program_registers(MAX_PREAMBLE, 0, 0, 0);
      send_frame_byte(8'hC3, 1'b1, 1'b1);
      send_frame_byte(8'h00, 1'b1, 1'b0);
      send_frame_byte(8'h0F, 1'b0, 1'b1);
      release_request();
      wait_idle();

      program_registers(0, MAX_LEAD, 2, 1);
      send_frame_byte(8'hE7, 1'b1, 1'b1);
      release_request();
      wait_idle();

      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         quiet_phase = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 9))
            0: pre = 0;
            1: pre = MAX_PREAMBLE;
            2: pre = 31;
            3: pre = MAX_PREAMBLE + 1;
            default: pre = $urandom_range(0, 3);
         endcase
         case ($urandom_range(0, 9))
            0: lead = 0;
            1: lead = MAX_LEAD;
            2: lead = 63;
            3: lead = MAX_LEAD + 1;
            default: lead = $urandom_range(1, 3);
         endcase
         program_registers(pre, lead, $urandom_range(0, 3), $urandom_range(0, 1));
         frames = $urandom_range(2, 6);
         for (int k = 0; k < frames; k++) begin
            len_pick = $urandom_range(0, 99);
            if (len_pick < 40)
               len = $urandom_range(1, 4);
            else if (len_pick < 70)
               len = $urandom_range(5, MIN_FRAME_BYTES - 2);
            else if (len_pick < 90)
               len = $urandom_range(MIN_FRAME_BYTES - 1, MIN_FRAME_BYTES + 1);
            else
               len = $urandom_range(MIN_FRAME_BYTES + 2, 30);
            send_frame(len, $urandom_range(0, 6) == 0);
         end
         release_request();
         wait_idle();
      end

      if (sb.errors == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule

// File: hdlc_nrzi_frame_transmitter_unit.f
hw/rtl/hnft_pkg.sv
hw/rtl/hnft_front.sv
hw/rtl/hnft_queue.sv
hw/rtl/hnft_back.sv
hw/rtl/hdlc_nrzi_frame_transmitter_unit.sv
tb/sv/tb.sv
